// ----- sv/srsw_pkg.sv -----
// Shared constants, slot codes and controller/datapath interface types for the ARQ sender window.
`timescale 1ns / 1ps
`default_nettype none

package srsw_pkg;

  // Sequence space and window size of the sender.
  localparam int SEQ_SPACE = 20;
  localparam int WINDOW    = 10;
  localparam int EFF_WIN   = (WINDOW > SEQ_SPACE) ? SEQ_SPACE : WINDOW;

  // Index and counter widths that follow from the sequence space.
  localparam int SLOT_W = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
  localparam int CNT_W  = $clog2(SEQ_SPACE + 1);

  // Fixed field widths.
  localparam int SEQ_FIELD_W = 5;
  localparam int TOTAL_W     = 16;
  localparam int TMO_W       = 8;
  localparam int POLL_W      = TMO_W + 1;

  // Register reset values.
  localparam logic [TOTAL_W-1:0] PACKET_TOTAL_RST  = 16'd100;
  localparam logic [TMO_W-1:0]   TIMEOUT_POLLS_RST = 8'd20;

  // Register word indexes on the configuration port.
  localparam logic REG_PACKET_TOTAL  = 1'b0;
  localparam logic REG_TIMEOUT_POLLS = 1'b1;

  typedef enum logic [1:0] {
    ST_FREE,
    ST_OUT,
    ST_RESEND,
    ST_ACKED
  } slot_st_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // take a new poll
    logic mark;     // mark the acknowledged slot and rewind to the base
    logic rewind;   // point at the base and clear the step counter
    logic slide;    // free the base slot and advance the base
    logic fire;     // record a timeout and clear the poll counter
    logic resend;   // turn an outstanding slot into a resend slot and step on
    logic advance;  // step on to the next window slot
    logic take;     // send the current slot
    logic emit;     // load the output register
  } srsw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ack_hit;
    logic slide_go;
    logic fire_due;
    logic resend_go;
    logic scan_go;
    logic scan_hit;
    logic out_free;
  } srsw_stat_t;

endpackage

`default_nettype wire

// ----- sv/selective_repeat_sender_window_core.sv -----
// Top level of the selective-repeat ARQ sender window: stream ports, register port and core.
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction is one poll and gives exactly one output transaction. A poll walks
// the slot status table one entry a cycle through a single read/write port: it marks the
// acknowledged slot when the acknowledgement lands in the window and slides the window over
// acknowledged base slots, turns the outstanding window slots into resend slots when a
// timeout fires, and scans at most WINDOW window slots for a sendable one. The result sits
// in an output register, so the next poll is accepted while it waits to be taken. Writing
// packet_total also reloads the count of packets left; configuration should only be written
// while the block is idle.
module selective_repeat_sender_window_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // Poll stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [4:0] ack_seq, [7:5] zero
  input  wire logic        s_tuser,   // [0] ack_valid
  // Send decision stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [4:0] send_seq, [5] timeout_fired,
                                      // [21:6] acked_total, [22] all_done, [23] zero
  output logic [1:0]       m_tuser,   // [0] send_valid, [1] is_resend
  // Register port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [srsw_pkg::TOTAL_W-1:0] packet_total;
  logic [srsw_pkg::TMO_W-1:0]   timeout_polls;
  logic                         wr_en;
  logic                         left_load;

  srsw_pkg::srsw_cmd_t  cmd;
  srsw_pkg::srsw_stat_t stat;

  logic                                send_valid;
  logic [srsw_pkg::SEQ_FIELD_W-1:0]    send_seq;
  logic                                is_resend;
  logic                                timeout_fired;
  logic [srsw_pkg::TOTAL_W-1:0]        acked_total;
  logic                                all_done;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;
  assign left_load = wr_en && (paddr[2] == srsw_pkg::REG_PACKET_TOTAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_total  <= srsw_pkg::PACKET_TOTAL_RST;
      timeout_polls <= srsw_pkg::TIMEOUT_POLLS_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        srsw_pkg::REG_PACKET_TOTAL:  packet_total  <= pwdata[srsw_pkg::TOTAL_W-1:0];
        srsw_pkg::REG_TIMEOUT_POLLS: timeout_polls <= pwdata[srsw_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      srsw_pkg::REG_PACKET_TOTAL:  prdata = 32'(packet_total);
      srsw_pkg::REG_TIMEOUT_POLLS: prdata = 32'(timeout_polls);
      default:                     prdata = '0;
    endcase
  end

  srsw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srsw_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .ack_valid     (s_tuser),
    .ack_seq       (s_tdata[srsw_pkg::SEQ_FIELD_W-1:0]),
    .left_load     (left_load),
    .left_value    (pwdata[srsw_pkg::TOTAL_W-1:0]),
    .timeout_polls (timeout_polls),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .send_valid    (send_valid),
    .send_seq      (send_seq),
    .is_resend     (is_resend),
    .timeout_fired (timeout_fired),
    .acked_total   (acked_total),
    .all_done      (all_done)
  );

  assign m_tdata = {1'b0, all_done, acked_total, timeout_fired, send_seq};
  assign m_tuser = {is_resend, send_valid};

endmodule

`default_nettype wire

// ----- sv/srsw_ctrl.sv -----
// Controller state machine that sequences one poll through the window datapath.
`timescale 1ns / 1ps
`default_nettype none

module srsw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire srsw_pkg::srsw_stat_t stat,
  output srsw_pkg::srsw_cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SLIDE,
    S_TIMEOUT,
    S_RESEND,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.ack_hit) begin
          cmd.mark   = 1'b1;
          state_next = S_SLIDE;
        end else begin
          cmd.rewind = 1'b1;
          state_next = S_TIMEOUT;
        end
      end
      S_SLIDE: begin
        if (stat.slide_go) begin
          cmd.slide = 1'b1;
        end else begin
          cmd.rewind = 1'b1;
          state_next = S_TIMEOUT;
        end
      end
      S_TIMEOUT: begin
        if (stat.fire_due) begin
          cmd.fire   = 1'b1;
          state_next = S_RESEND;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_RESEND: begin
        if (stat.resend_go) begin
          cmd.resend = 1'b1;
        end else begin
          cmd.rewind = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_go && stat.scan_hit) begin
          cmd.take   = 1'b1;
          state_next = S_DONE;
        end else if (stat.scan_go) begin
          cmd.advance = 1'b1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/srsw_dpath.sv -----
// Datapath: slot status table, window base, counters and the output register.
`timescale 1ns / 1ps
`default_nettype none

module srsw_dpath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire srsw_pkg::srsw_cmd_t                cmd,
  output srsw_pkg::srsw_stat_t                    stat,
  input  wire logic                               ack_valid,
  input  wire logic [srsw_pkg::SEQ_FIELD_W-1:0]   ack_seq,
  input  wire logic                               left_load,
  input  wire logic [srsw_pkg::TOTAL_W-1:0]       left_value,
  input  wire logic [srsw_pkg::TMO_W-1:0]         timeout_polls,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic                                    send_valid,
  output logic [srsw_pkg::SEQ_FIELD_W-1:0]        send_seq,
  output logic                                    is_resend,
  output logic                                    timeout_fired,
  output logic [srsw_pkg::TOTAL_W-1:0]            acked_total,
  output logic                                    all_done
);

  localparam int SW = srsw_pkg::SLOT_W;
  localparam int CW = srsw_pkg::CNT_W;
  localparam int TW = srsw_pkg::TOTAL_W;

  srsw_pkg::slot_st_t slots [srsw_pkg::SEQ_SPACE];

  logic [SW-1:0]                  base;
  logic [SW-1:0]                  idx;
  logic [CW-1:0]                  step;
  logic                           ack_in;
  logic [SW-1:0]                  ack_slot;
  logic [srsw_pkg::POLL_W-1:0]    poll;
  logic [TW-1:0]                  pkt_left;
  logic [TW-1:0]                  acked;
  logic                           fired;
  logic                           res_sv;
  logic [SW-1:0]                  res_seq;
  logic                           res_rs;

  srsw_pkg::slot_st_t slot_rd;
  logic [SW-1:0]      idx_inc;
  logic [SW:0]        off_sum;
  logic [SW:0]        off;

  assign slot_rd = slots[idx];
  assign idx_inc = (idx == SW'(srsw_pkg::SEQ_SPACE - 1)) ? '0 : idx + 1'b1;

  // Distance of the acknowledged slot from the base, modulo the sequence space.
  assign off_sum = {1'b0, ack_slot} + (SW + 1)'(srsw_pkg::SEQ_SPACE) - {1'b0, base};
  assign off     = (off_sum >= (SW + 1)'(srsw_pkg::SEQ_SPACE)) ?
                   off_sum - (SW + 1)'(srsw_pkg::SEQ_SPACE) : off_sum;

  always_comb begin
    stat.ack_hit   = ack_in && (off < (SW + 1)'(srsw_pkg::EFF_WIN));
    stat.slide_go  = (slot_rd == srsw_pkg::ST_ACKED) && (step < CW'(srsw_pkg::SEQ_SPACE));
    stat.fire_due  = poll > {1'b0, timeout_polls};
    stat.resend_go = step < CW'(srsw_pkg::EFF_WIN);
    stat.scan_go   = (step < CW'(srsw_pkg::EFF_WIN)) && (TW'(step) < pkt_left);
    stat.scan_hit  = (slot_rd == srsw_pkg::ST_FREE) || (slot_rd == srsw_pkg::ST_RESEND);
    stat.out_free  = !out_valid || out_ready;
  end

  // Status table: one read and one write a cycle, both at the walking index.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < srsw_pkg::SEQ_SPACE; i++) begin
        slots[i] <= srsw_pkg::ST_FREE;
      end
    end else if (cmd.mark) begin
      slots[idx] <= srsw_pkg::ST_ACKED;
    end else if (cmd.slide) begin
      slots[idx] <= srsw_pkg::ST_FREE;
    end else if (cmd.resend && (slot_rd == srsw_pkg::ST_OUT)) begin
      slots[idx] <= srsw_pkg::ST_RESEND;
    end else if (cmd.take) begin
      slots[idx] <= srsw_pkg::ST_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base     <= '0;
      idx      <= '0;
      step     <= '0;
      ack_in   <= 1'b0;
      poll     <= '0;
      pkt_left <= srsw_pkg::PACKET_TOTAL_RST;
      acked    <= '0;
      fired    <= 1'b0;
      res_sv   <= 1'b0;
      res_rs   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (left_load) begin
        pkt_left <= left_value;
      end
      if (cmd.load) begin
        // An acknowledgement counts only when it names a slot of the sequence space.
        ack_in   <= ack_valid && (int'(ack_seq) < srsw_pkg::SEQ_SPACE);
        ack_slot <= SW'(ack_seq);
        idx      <= SW'(ack_seq);
        poll     <= poll + 1'b1;
        fired    <= 1'b0;
        res_sv   <= 1'b0;
        res_rs   <= 1'b0;
        res_seq  <= '0;
      end
      if (cmd.mark || cmd.rewind) begin
        idx  <= (cmd.mark) ? base : base;
        step <= '0;
      end
      if (cmd.slide) begin
        base <= idx_inc;
        idx  <= idx_inc;
        step <= step + 1'b1;
        poll <= '0;
        if (acked != '1) begin
          acked <= acked + 1'b1;
        end
        if (pkt_left != '0) begin
          pkt_left <= pkt_left - 1'b1;
        end
      end
      if (cmd.fire) begin
        fired <= 1'b1;
        poll  <= '0;
      end
      if (cmd.resend || cmd.advance) begin
        idx  <= idx_inc;
        step <= step + 1'b1;
      end
      if (cmd.take) begin
        res_sv  <= 1'b1;
        res_seq <= idx;
        res_rs  <= (slot_rd == srsw_pkg::ST_RESEND);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      send_valid    <= res_sv;
      send_seq      <= srsw_pkg::SEQ_FIELD_W'(res_seq);
      is_resend     <= res_rs;
      timeout_fired <= fired;
      acked_total   <= acked;
      all_done      <= (pkt_left == '0);
    end
  end

endmodule

`default_nettype wire
